// ===== rtl/cdt_pkg.sv =====
// ----------------------------------------------------------------------------
// cdt_pkg
// Shared types, constants and helper functions of the countdown timer:
// payload structs, register indexes, bcd arithmetic and segment decoding.
// ----------------------------------------------------------------------------
`default_nettype none

package cdt_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_LEN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEC_LEN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REP_DELAY = 2'd2;
  localparam int unsigned CFG_DATA_W = 16;

  // register reset values
  localparam logic [7:0]  TICK_LEN_RST  = 8'd10;
  localparam logic [15:0] SEC_LEN_RST   = 16'd1000;
  localparam logic [15:0] REP_DELAY_RST = 16'd450;

  // hold time and repeat timing
  localparam logic [15:0] HOLD_MAX      = 16'hFFFF;
  localparam logic [15:0] HOLD_STEP_1   = 16'd800;
  localparam logic [15:0] HOLD_STEP_2   = 16'd1600;
  localparam logic [15:0] HOLD_STEP_3   = 16'd3000;
  localparam logic [15:0] REP_IVL_SLOW  = 16'd200;
  localparam logic [15:0] REP_IVL_MID   = 16'd120;
  localparam logic [15:0] REP_IVL_FAST  = 16'd70;
  localparam logic [15:0] REP_IVL_TOP   = 16'd40;

  // counter kept as four bcd digits, ones in element 0
  typedef logic [3:0]      bcd_digit_t;
  typedef logic [3:0][3:0] bcd_t;

  // input item
  typedef struct packed {
    logic start_key_n;
    logic up_key_n;
    logic down_key_n;
  } in_t;

  // result item
  typedef struct packed {
    logic [13:0] count_value;
    logic        is_running;
    logic [6:0]  seg_ones;
    logic [6:0]  seg_tens;
    logic [6:0]  seg_hundreds;
    logic [6:0]  seg_thousands;
  } out_t;

  // timing settings shared by both repeat keys
  typedef struct packed {
    logic [7:0]  tick_len;
    logic [15:0] rep_delay;
  } key_cfg_t;

  // repeat interval for a given hold time
  function automatic logic [15:0] rep_interval(logic [15:0] hold);
    if (hold < HOLD_STEP_1) begin
      return REP_IVL_SLOW;
    end else if (hold < HOLD_STEP_2) begin
      return REP_IVL_MID;
    end else if (hold < HOLD_STEP_3) begin
      return REP_IVL_FAST;
    end
    return REP_IVL_TOP;
  endfunction

  // bcd increment, 9999 wraps to 0
  function automatic bcd_t bcd_inc(bcd_t v);
    bcd_t r;
    logic c;
    r = v;
    c = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if (c) begin
        if (r[i] == 4'd9) begin
          r[i] = 4'd0;
        end else begin
          r[i] = r[i] + 4'd1;
          c    = 1'b0;
        end
      end
    end
    return r;
  endfunction

  // bcd decrement, stays at 0
  function automatic bcd_t bcd_dec_sat(bcd_t v);
    bcd_t r;
    logic b;
    r = v;
    b = (v != '0);
    for (int i = 0; i < 4; i++) begin
      if (b) begin
        if (r[i] == 4'd0) begin
          r[i] = 4'd9;
        end else begin
          r[i] = r[i] - 4'd1;
          b    = 1'b0;
        end
      end
    end
    return r;
  endfunction

  // bcd to binary by constant weights
  function automatic logic [13:0] bcd_to_bin(bcd_t v);
    return ({10'd0, v[3]} * 14'd1000) + ({10'd0, v[2]} * 14'd100)
         + ({10'd0, v[1]} * 14'd10) + {10'd0, v[0]};
  endfunction

  // seven-segment pattern, bit0 = segment a
  function automatic logic [6:0] seg_of(bcd_digit_t d);
    logic [6:0] s;
    case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/countdown_timer_with_repeat_keys.sv =====
// ----------------------------------------------------------------------------
// countdown_timer_with_repeat_keys
// Tick-driven countdown timer with start/stop and auto-repeat set keys,
// giving the count, the running flag and four seven-segment patterns.
// ----------------------------------------------------------------------------
// Output: the result of a tick is registered and valid in the cycle after its transfer.
// Throughput: one tick per cycle; the output register lets a new tick in
// while its result drains, so only a stalled full output register holds input.
// Reset: asynchronous, active low; count 0, stopped, keys released and
// configuration registers at 10 ms tick, 1000 ms step and 450 ms delay.
`default_nettype none

module countdown_timer_with_repeat_keys import cdt_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration write channel
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // tick input
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire in_t                  in_data_i,
  // result output
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output out_t                      out_data_o
);

  logic [7:0]  tick_len_q;
  logic [15:0] sec_len_q;
  logic [15:0] rep_delay_q;
  key_cfg_t    key_cfg;

  logic        start_last_q;
  logic        run_q, run_d, run_a;
  logic [15:0] accum_q, accum_d;
  bcd_t        cnt_q, cnt_d, cnt_a, cnt_b;
  logic [16:0] sec_sum;
  logic        in_acc;
  logic        up_fire, dn_fire;
  logic        out_valid_q;
  out_t        out_data_q, out_d;

  // configuration registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_len_q  <= TICK_LEN_RST;
      sec_len_q   <= SEC_LEN_RST;
      rep_delay_q <= REP_DELAY_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_TICK_LEN:  tick_len_q  <= cfg_data_i[7:0];
        CFG_SEC_LEN:   sec_len_q   <= cfg_data_i;
        CFG_REP_DELAY: rep_delay_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign key_cfg.tick_len  = tick_len_q;
  assign key_cfg.rep_delay = rep_delay_q;

  // handshake: stall only when a result waits and is held downstream
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;

  // repeat keys
  cdt_key u_up_key (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_acc),
    .key_n_i  (in_data_i.up_key_n),
    .cfg_i    (key_cfg),
    .fire_o   (up_fire)
  );

  cdt_key u_dn_key (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_acc),
    .key_n_i  (in_data_i.down_key_n),
    .cfg_i    (key_cfg),
    .fire_o   (dn_fire)
  );

  // start toggle, key steps, then countdown
  assign run_a   = run_q ^ (start_last_q & ~in_data_i.start_key_n);
  assign cnt_a   = up_fire ? bcd_inc(cnt_q) : cnt_q;
  assign cnt_b   = dn_fire ? bcd_dec_sat(cnt_a) : cnt_a;
  assign sec_sum = {1'b0, accum_q} + {9'd0, tick_len_q};

  always_comb begin
    run_d   = run_a;
    cnt_d   = cnt_b;
    accum_d = '0;
    if (run_a) begin
      if (sec_sum >= {1'b0, sec_len_q}) begin
        if (cnt_b != '0) begin
          cnt_d = bcd_dec_sat(cnt_b);
        end else begin
          run_d = 1'b0;
        end
      end else begin
        accum_d = sec_sum[15:0];
      end
    end
  end

  // timer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_last_q <= 1'b1;
      run_q        <= 1'b0;
      accum_q      <= '0;
      cnt_q        <= '0;
    end else if (in_acc) begin
      start_last_q <= in_data_i.start_key_n;
      run_q        <= run_d;
      accum_q      <= accum_d;
      cnt_q        <= cnt_d;
    end
  end

  // result formatting
  assign out_d.count_value   = bcd_to_bin(cnt_d);
  assign out_d.is_running    = run_d;
  assign out_d.seg_ones      = seg_of(cnt_d[0]);
  assign out_d.seg_tens      = seg_of(cnt_d[1]);
  assign out_d.seg_hundreds  = seg_of(cnt_d[2]);
  assign out_d.seg_thousands = seg_of(cnt_d[3]);

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= in_acc | (out_valid_q & out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_data_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // checks
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.count_value <= 14'd9999))
    else $error("count out of range");

  a_valid_from_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_acc))
    else $error("result without input transfer");

  a_accum_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (run_q || (accum_q == 16'd0)))
    else $error("second accumulator kept while stopped");

  a_no_spurious_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !run_q && !(start_last_q && !in_data_i.start_key_n)) |=> !run_q)
    else $error("timer started without start press");

endmodule

`default_nettype wire

// ===== rtl/cdt_key.sv =====
// ----------------------------------------------------------------------------
// cdt_key
// One auto-repeat key: press edge detect, saturating hold timer and a
// repeat accumulator whose interval shortens as the hold goes on.
// ----------------------------------------------------------------------------
`default_nettype none

module cdt_key import cdt_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     accept_i,
  input  wire logic     key_n_i,
  input  wire key_cfg_t cfg_i,
  output logic          fire_o
);

  logic        last_q, last_d;
  logic [15:0] hold_q, hold_d;
  logic [15:0] acc_q, acc_d;
  logic        press;
  logic [16:0] hold_sum;
  logic [16:0] acc_sum;
  logic [15:0] hold_sat;
  logic [15:0] acc_sat;

  // saturating sums of the tick length
  assign hold_sum = {1'b0, hold_q} + {9'd0, cfg_i.tick_len};
  assign hold_sat = hold_sum[16] ? HOLD_MAX : hold_sum[15:0];
  assign acc_sum  = {1'b0, acc_q} + {9'd0, cfg_i.tick_len};
  assign acc_sat  = acc_sum[16] ? HOLD_MAX : acc_sum[15:0];
  assign press    = last_q & ~key_n_i;

  // next key state and fire decision
  always_comb begin
    last_d = key_n_i;
    hold_d = hold_q;
    acc_d  = acc_q;
    fire_o = 1'b0;
    if (press) begin
      hold_d = '0;
      acc_d  = '0;
      fire_o = 1'b1;
    end else if (!key_n_i) begin
      hold_d = hold_sat;
      if (hold_sat >= cfg_i.rep_delay) begin
        if (acc_sat >= rep_interval(hold_sat)) begin
          acc_d  = '0;
          fire_o = 1'b1;
        end else begin
          acc_d = acc_sat;
        end
      end
    end else begin
      hold_d = '0;
      acc_d  = '0;
    end
  end

  // state update per transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= 1'b1;
      hold_q <= '0;
      acc_q  <= '0;
    end else if (accept_i) begin
      last_q <= last_d;
      hold_q <= hold_d;
      acc_q  <= acc_d;
    end
  end

endmodule

`default_nettype wire
